>>> sv/lhr_pkg.sv
// ----------------------------------------------------------------------------
// lhr_pkg
// Shared widths, register map and reset values for the lookback history ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lhr_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 7;
    localparam int BW    = 8;

    localparam int PAW   = 3;
    localparam int PDW   = 32;

    localparam logic       REG_RING_SIZE = 1'b0;
    localparam logic [CW-1:0] RING_SIZE_RST = CW'(64);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

endpackage

`default_nettype wire

>>> sv/lhr_if.sv
// ----------------------------------------------------------------------------
// lhr_if
// Request and result channels of the lookback history ring.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhr_in_if;
    import lhr_pkg::*;

    logic          valid;
    logic          ready;
    logic          cmd;
    logic [BW-1:0] data_byte;
    logic [CW-1:0] read_count;

    modport source (output valid, cmd, data_byte, read_count, input ready);
    modport sink   (input valid, cmd, data_byte, read_count, output ready);
endinterface

interface lhr_out_if;
    import lhr_pkg::*;

    logic          valid;
    logic          ready;
    logic [BW-1:0] out_byte;
    logic          last;
    logic          empty_res;
    logic [CW-1:0] total;

    modport source (output valid, out_byte, last, empty_res, total, input ready);
    modport sink   (input valid, out_byte, last, empty_res, total, output ready);
endinterface

`default_nettype wire

>>> sv/lookback_history_ring.sv
// ----------------------------------------------------------------------------
// lookback_history_ring
// Ring store of the newest bytes pushed; a read request drains the newest
// bytes oldest first and clears the ring.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  i_in    | in  | cmd, data_byte, read_count           | valid / ready
//  o_out   | out | out_byte, last, empty_res, total     | valid / ready
//  apb     | in  | ring_size at byte address 0          | psel, penable, pready
//
//  A push gives no result.
//  A read is accepted, then the ring issues one store read a cycle while
//  the result side keeps up; bytes leave one a cycle, through the store
//  read register and the output register. Requests are refused until the
//  last byte of the run has been read from the store.
//  Synchronous active-low reset clears control state; store contents stay
//  undefined until pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module lookback_history_ring (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    lhr_in_if.sink                  i_in,
    lhr_out_if.source               o_out,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [lhr_pkg::PAW-1:0]  paddr,
    input  wire [lhr_pkg::PDW-1:0]  pwdata,
    output logic [lhr_pkg::PDW-1:0] prdata,
    output logic                    pready
);
    import lhr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    logic [BW-1:0] mem [DEPTH];

    t_state        r_state,     n_state;
    logic [CW-1:0] r_ring_size;
    logic [AW-1:0] r_head,      n_head;
    logic [CW-1:0] r_fill,      n_fill;
    logic [CW-1:0] r_rem,       n_rem;
    logic [AW-1:0] r_addr,      n_addr;
    logic [CW-1:0] r_total,     n_total;
    logic          r_empty,     n_empty;

    logic          r_dv,        n_dv;
    logic [BW-1:0] r_rd_data;
    logic          r_d_last;
    logic          r_d_empty;
    logic [CW-1:0] r_d_total;

    logic          r_ov,        n_ov;
    logic [BW-1:0] r_out_byte;
    logic          r_out_last;
    logic          r_out_empty;
    logic [CW-1:0] r_out_total;

    logic          cfg_wr;
    logic [CW-1:0] size;
    logic          in_acc;
    logic          push;
    logic          load;
    logic          issue;
    logic [CW-1:0] run;
    logic [CW:0]   start_sum;
    logic [CW:0]   start_pos;
    logic [AW-1:0] addr_inc;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_RING_SIZE);
    assign prdata = (paddr[2] == REG_RING_SIZE) ? PDW'(r_ring_size) : '0;

    always_comb begin
        if (r_ring_size == '0) begin
            size = CW'(1);
        end else if (r_ring_size > CW'(DEPTH)) begin
            size = CW'(DEPTH);
        end else begin
            size = r_ring_size;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;
    assign push       = in_acc & (i_in.cmd == CMD_PUSH);

    assign load  = r_dv & (~r_ov | o_out.ready);
    assign issue = (r_state == ST_RUN) & (~r_dv | load);

    assign run       = (i_in.read_count < r_fill) ? i_in.read_count : r_fill;
    assign start_sum = (CW+1)'(r_head) + (CW+1)'(size) - (CW+1)'(run);
    assign start_pos = (start_sum >= (CW+1)'(size)) ? start_sum - (CW+1)'(size)
                                                    : start_sum;
    assign addr_inc  = (CW'(r_addr) + CW'(1) == size) ? '0 : r_addr + AW'(1);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_fill  = r_fill;
        n_rem   = r_rem;
        n_addr  = r_addr;
        n_total = r_total;
        n_empty = r_empty;
        n_dv    = load ? 1'b0 : r_dv;
        n_ov    = (o_out.ready) ? 1'b0 : r_ov;
        if (load) begin
            n_ov = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (push) begin
                    n_head = (CW'(r_head) + CW'(1) == size) ? '0 : r_head + AW'(1);
                    n_fill = (r_fill + CW'(1) > size) ? size : r_fill + CW'(1);
                end else if (in_acc) begin
                    n_head  = '0;
                    n_fill  = '0;
                    n_rem   = run;
                    n_total = run;
                    n_empty = (run == '0);
                    n_addr  = AW'(start_pos);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_dv   = 1'b1;
                    n_rem  = r_rem - CW'(1);
                    n_addr = addr_inc;
                    if (r_empty || r_rem == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cfg_wr) begin
            n_head = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ring_size <= RING_SIZE_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_rem       <= '0;
            r_empty     <= 1'b0;
            r_dv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_rem   <= n_rem;
            r_empty <= n_empty;
            r_dv    <= n_dv;
            r_ov    <= n_ov;
            if (cfg_wr) begin
                r_ring_size <= pwdata[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_total <= n_total;
        if (issue) begin
            r_d_last  <= r_empty | (r_rem == CW'(1));
            r_d_empty <= r_empty;
            r_d_total <= r_total;
        end
        if (load) begin
            r_out_byte  <= r_d_empty ? '0 : r_rd_data;
            r_out_last  <= r_d_last;
            r_out_empty <= r_d_empty;
            r_out_total <= r_d_total;
        end
    end

    // store: one write port for pushes, one registered read port for runs
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_head] <= i_in.data_byte;
        end
        if (issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last      = r_out_last;
    assign o_out.empty_res = r_out_empty;
    assign o_out.total     = r_out_total;

endmodule

`default_nettype wire

>>> sv/lhr_checker.sv
// ----------------------------------------------------------------------------
// lhr_checker
// Port-level checks on the lookback history ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lhr_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_ready,
    input wire                    i_out_valid,
    input wire                    i_out_ready,
    input wire [lhr_pkg::BW-1:0]  i_out_byte,
    input wire                    i_out_last,
    input wire                    i_out_empty,
    input wire [lhr_pkg::CW-1:0]  i_out_total
);
    import lhr_pkg::*;

    // empty read result carries a fixed payload
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_empty) |->
            (i_out_last && i_out_total == '0 && i_out_byte == '0))
        else $error("empty result with bad payload");

    // a non-empty byte reports a run length of at least one
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_empty) |-> (i_out_total != '0))
        else $error("byte result with zero total");

    // run length stays constant until the last byte of the run
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (!i_out_valid || i_out_total == $past(i_out_total)))
        else $error("total changed inside a run");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not quiet after reset");

endmodule

bind lookback_history_ring lhr_checker u_lhr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last),
    .i_out_empty (o_out.empty_res),
    .i_out_total (o_out.total)
);

`default_nettype wire

>>> verif/lookback_history_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lookback_history_ring_tb
// Drives push and read requests through the request channel with bursty
// timing, stalls the result channel on its own pattern, and steps ring_size
// over the APB port between phases. A scoreboard tracks the ring state and
// compares every read-back byte against the bytes it predicts.
// ----------------------------------------------------------------------------

module lookback_history_ring_tb;
    import lhr_pkg::*;

    typedef struct packed {
        logic [BW-1:0] value;
        logic          last;
        logic          is_empty;
        logic [CW-1:0] total;
    } t_readback;

    class history_scoreboard;
        logic [BW-1:0] ring_bytes [DEPTH];
        int unsigned   wr_ptr;
        int unsigned   stored;
        logic [CW-1:0] size_reg;
        t_readback     pending [$];
        int unsigned   errors;
        int unsigned   results_seen;

        function new();
            foreach (ring_bytes[k]) ring_bytes[k] = '0;
            wr_ptr = 0;
            stored = 0;
            size_reg = RING_SIZE_RST;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_ring_size(logic [CW-1:0] value);
            size_reg = value;
            wr_ptr = 0;
            stored = 0;
        endfunction

        function int unsigned active_size();
            if (size_reg == 0) return 1;
            if (size_reg > DEPTH) return DEPTH;
            return size_reg;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) $display("[%0t] %s", $time, what);
        endfunction

        function void note_request(logic cmd, logic [BW-1:0] data, logic [CW-1:0] count);
            int unsigned size, ptr, fill, run, pos;
            t_readback   rb;
            size = active_size();
            ptr  = wr_ptr % size;
            fill = stored > size ? size : stored;
            if (cmd == CMD_PUSH) begin
                ring_bytes[ptr] = data;
                wr_ptr = (ptr + 1) % size;
                stored = (fill + 1 > size) ? size : fill + 1;
                return;
            end
            run = count < fill ? count : fill;
            wr_ptr = 0;
            stored = 0;
            if (run == 0) begin
                rb = '{value: '0, last: 1'b1, is_empty: 1'b1, total: '0};
                pending.push_back(rb);
                return;
            end
            for (int unsigned i = 0; i < run; i++) begin
                pos = (ptr + size - run + i) % size;
                rb = '{value: ring_bytes[pos], last: (i + 1 == run), is_empty: 1'b0,
                       total: CW'(run)};
                pending.push_back(rb);
            end
        endfunction

        function void check_result(logic [BW-1:0] got_byte, logic got_last,
                                   logic got_empty, logic [CW-1:0] got_total);
            t_readback want;
            results_seen++;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected result byte=%0h last=%0b empty=%0b total=%0d",
                               got_byte, got_last, got_empty, got_total));
                return;
            end
            want = pending.pop_front();
            if (got_byte !== want.value || got_last !== want.last ||
                got_empty !== want.is_empty || got_total !== want.total) begin
                flag($sformatf({"mismatch: exp byte=%0h last=%0b empty=%0b total=%0d",
                                " got byte=%0h last=%0b empty=%0b total=%0d"},
                               want.value, want.last, want.is_empty, want.total,
                               got_byte, got_last, got_empty, got_total));
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;

    lhr_in_if  req_if ();
    lhr_out_if res_if ();

    history_scoreboard sb = new();
    int burst_left = 10;

    lookback_history_ring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.out_byte, res_if.last, res_if.empty_res, res_if.total);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.cmd, req_if.data_byte, req_if.read_count);
        end
    end

    // request offered until taken; valid stays up into the next request of a burst
    task automatic offer_request(logic cmd, logic [BW-1:0] data, logic [CW-1:0] count);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.data_byte  <= data;
        req_if.read_count <= count;
        do @(posedge i_clk); while (!req_if.ready);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic push_byte(logic [BW-1:0] data);
        offer_request(CMD_PUSH, data, CW'($urandom_range(0, 127)));
    endtask

    task automatic fetch_newest(logic [CW-1:0] count);
        offer_request(CMD_READ, BW'($urandom_range(0, 255)), count);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_ring_size(logic [CW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAW'(4 * int'(REG_RING_SIZE));
        pwdata  <= PDW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_ring_size(value);
    endtask

    initial begin : result_stall
        int mode;
        int mode_left;
        int hold_left;
        bit held_off;
        bit rdy;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held_off = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // one long hold-off mid-run so the ring backs up into the request side
            if (!held_off && sb.results_seen >= 60 && res_if.valid && !res_if.last) begin
                held_off = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(4, 40);
                end
                mode_left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 5) == 0);
                    default: rdy = mode_left[0];
                endcase
            end
            res_if.ready <= rdy;
        end
    end

    initial begin : stimulus
        int phase_sizes [8];
        int asize;
        int n;
        int kept;
        int count;
        int sent;
        phase_sizes = '{64, 1, 0, 127, 2, 65, 0, 64};
        phase_sizes[6] = $urandom_range(3, 63);

        req_if.valid      <= 1'b0;
        req_if.cmd        <= CMD_PUSH;
        req_if.data_byte  <= '0;
        req_if.read_count <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, zero count, saturation, partial read
        fetch_newest(CW'(5));
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        fetch_newest(CW'(0));
        push_byte(8'h5A);
        push_byte(8'h80);
        push_byte(8'h01);
        fetch_newest(CW'(64));
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        push_byte(8'h44);
        fetch_newest(CW'(2));
        fetch_newest(CW'(1));
        wait_drained();
        write_ring_size(CW'(1));
        push_byte(8'h7E);
        push_byte(8'hC3);
        fetch_newest(CW'(63));
        wait_drained();
        write_ring_size(CW'(0));
        push_byte(8'h3C);
        fetch_newest(CW'(1));
        wait_drained();
        write_ring_size(CW'(2));
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        fetch_newest(CW'(2));

        foreach (phase_sizes[p]) begin
            wait_drained();
            write_ring_size(CW'(phase_sizes[p]));
            sent = 0;
            while (sent < 40) begin
                asize = sb.active_size();
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 3) == 0)
                        n = $urandom_range(asize, asize + 8);
                    else
                        n = $urandom_range(0, 12);
                    repeat (n) push_byte(BW'($urandom_range(0, 255)));
                    kept = n < asize ? n : asize;
                    case ($urandom_range(0, 4))
                        0: count = 0;
                        1: count = 1;
                        2: count = kept;
                        3: count = 64;
                        default: count = $urandom_range(0, 64);
                    endcase
                    fetch_newest(CW'(count));
                    sent += n + 1;
                end else if ($urandom_range(0, 1) == 1) begin
                    fetch_newest(CW'($urandom_range(0, 64)));
                    sent++;
                end else begin
                    push_byte(BW'($urandom_range(0, 255)));
                    sent++;
                end
            end
            // bytes left in the ring here are cleared by the size write of the next phase, if any
            repeat ($urandom_range(0, 3)) push_byte(BW'($urandom_range(0, 255)));
        end
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
sv/lhr_pkg.sv
sv/lhr_if.sv
sv/lookback_history_ring.sv
sv/lhr_checker.sv
verif/lookback_history_ring_tb.sv
